### rtl/fspa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fspa_pkg
// Shared types, widths and codes of the fixed slot pool allocator.
// ----------------------------------------------------------------------------
package fspa_pkg;

    // pool geometry
    localparam int SLOTS      = 1024;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 17;
    localparam int SPAN_W     = SIZE_W + IDX_W;
    localparam int STEP_W     = (IDX_W > 1) ? $clog2(IDX_W) : 1;
    localparam int MEM_W      = IDX_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ADDR_W;

    // element size limits
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(16);
    localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(65536);

    // request codes
    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FOREIGN = 2'd2;
    localparam logic [1:0] ST_DOUBLE  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SIZE = CFG_IDX_W'(1);

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] addr;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] elem_addr;
        logic [CNT_W-1:0]  used_count;
    } t_out_item;

    // zero gives the minimum, else round up to 16 bytes and saturate
    function automatic logic [SIZE_W-1:0] effective_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W:0] rounded;
        logic [SIZE_W:0] res;
        rounded = ({1'b0, v} + (SIZE_W + 1)'(15)) & ~((SIZE_W + 1)'(15));
        if (v == '0) begin
            res = {1'b0, SIZE_MIN};
        end else if (rounded > {1'b0, SIZE_CAP}) begin
            res = {1'b0, SIZE_CAP};
        end else begin
            res = rounded;
        end
        return res[SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/fixed_slot_pool_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_slot_pool_allocator
// Pool of equal sized elements with a LIFO reuse chain and allocated flags,
// kept together in one single-port synchronous memory.
// ----------------------------------------------------------------------------
// Allocate: memory read and write back, or a write for a never used slot, then
//   multiply and add. Free: an address beyond the pool ends at the range check,
//   else the ten-step restoring divider turns the address offset into a slot index.
// One transaction is in work at a time; the next is taken the cycle after the
//   result moves to the output register.
// After reset a clearing pass zeroes the flag and link memory; input stalls.
module fixed_slot_pool_allocator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [fspa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [fspa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire fspa_pkg::t_in_item                  i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output fspa_pkg::t_out_item                      o_out
);
    import fspa_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_RANGE    = 11'b000_0000_0100,
        S_DIV      = 11'b000_0000_1000,
        S_FREE_RD  = 11'b000_0001_0000,
        S_FREE_WB  = 11'b000_0010_0000,
        S_ALLOC    = 11'b000_0100_0000,
        S_ALLOC_WB = 11'b000_1000_0000,
        S_MUL      = 11'b001_0000_0000,
        S_ADD      = 11'b010_0000_0000,
        S_DONE     = 11'b100_0000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;

    // configuration
    logic [ADDR_W-1:0]   r_pool_base;
    logic [SIZE_W-1:0]   r_elem_size;

    // allocator state
    logic [IDX_W-1:0]    r_head;
    logic [CNT_W-1:0]    r_fresh;
    logic [CNT_W-1:0]    r_in_use;
    logic [IDX_W-1:0]    r_clr_idx;

    // transaction datapath
    logic [ADDR_W-1:0]   r_offset;
    logic [SPAN_W-1:0]   r_rem;
    logic [IDX_W-1:0]    r_q;
    logic [STEP_W-1:0]   r_step;
    logic [IDX_W-1:0]    r_idx;
    logic [SPAN_W-1:0]   r_prod;
    logic [1:0]          r_status;
    logic [ADDR_W-1:0]   r_elem_addr;

    // output register
    logic                r_out_valid;
    t_out_item           r_out;

    // memory: {taken flag, reuse link}
    logic [MEM_W-1:0]    r_mem [SLOTS];
    logic [MEM_W-1:0]    r_mem_q;
    logic                w_mem_we;
    logic [IDX_W-1:0]    w_mem_waddr;
    logic [MEM_W-1:0]    w_mem_wdata;
    logic                w_mem_re;
    logic [IDX_W-1:0]    w_mem_raddr;

    logic                w_in_acc;
    logic                w_out_load;
    logic [CNT_W-1:0]    w_waiting;
    logic [ADDR_W-1:0]   w_span;
    logic [SPAN_W-1:0]   w_trial;
    logic                w_taken;
    logic [CNT_W-1:0]    w_fresh_dec;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_waiting   = CNT_W'(SLOTS) - r_fresh - r_in_use;
    assign w_span      = ADDR_W'(r_elem_size) * ADDR_W'(SLOTS);
    assign w_trial     = SPAN_W'(r_elem_size) << r_step;
    assign w_taken     = r_mem_q[MEM_W-1];
    assign w_fresh_dec = r_fresh - CNT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr_idx == IDX_W'(SLOTS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in.func == FN_FREE) ? S_RANGE : S_ALLOC;
                end
            end
            S_RANGE:    n_state = (r_offset >= w_span) ? S_DONE : S_DIV;
            S_DIV:      if (r_step == '0) n_state = S_FREE_RD;
            S_FREE_RD:  n_state = (r_rem != '0) ? S_DONE : S_FREE_WB;
            S_FREE_WB:  n_state = S_DONE;
            S_ALLOC: begin
                if (w_waiting != '0) begin
                    n_state = S_ALLOC_WB;
                end else if (r_fresh != '0) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ALLOC_WB: n_state = S_MUL;
            S_MUL:      n_state = S_ADD;
            S_ADD:      n_state = S_DONE;
            S_DONE:     if (w_out_load) n_state = S_IDLE;
            default:    n_state = S_CLEAR;
        endcase
    end

    // memory port control
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_clr_idx;
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_head;
        unique case (r_state)
            S_CLEAR: w_mem_we = 1'b1;
            S_ALLOC: begin
                if (w_waiting != '0) begin
                    w_mem_re    = 1'b1;
                    w_mem_raddr = r_head;
                end else if (r_fresh != '0) begin
                    w_mem_we    = 1'b1;
                    w_mem_waddr = w_fresh_dec[IDX_W-1:0];
                    w_mem_wdata = {1'b1, IDX_W'(0)};
                end
            end
            S_ALLOC_WB: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_head;
                w_mem_wdata = {1'b1, r_mem_q[IDX_W-1:0]};
            end
            S_FREE_RD: begin
                w_mem_re    = (r_rem == '0);
                w_mem_raddr = r_q;
            end
            S_FREE_WB: begin
                w_mem_we    = w_taken;
                w_mem_waddr = r_q;
                w_mem_wdata = {1'b0, r_head};
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // flag and link memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_mem_q <= r_mem[w_mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base <= '0;
            r_elem_size <= SIZE_MIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_POOL_BASE: r_pool_base <= i_cfg_data[ADDR_W-1:0];
                CFG_ELEM_SIZE: r_elem_size <= effective_size(i_cfg_data[SIZE_W-1:0]);
                default:       r_pool_base <= r_pool_base;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_head      <= '0;
            r_fresh     <= CNT_W'(SLOTS);
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            // pop from the reuse chain or take a never used slot
            if (r_state == S_ALLOC) begin
                if (w_waiting == '0 && r_fresh != '0) begin
                    r_fresh  <= w_fresh_dec;
                    r_in_use <= r_in_use + CNT_W'(1);
                end
            end
            if (r_state == S_ALLOC_WB) begin
                r_head   <= r_mem_q[IDX_W-1:0];
                r_in_use <= r_in_use + CNT_W'(1);
            end
            // push a freed slot
            if (r_state == S_FREE_WB && w_taken) begin
                r_head <= r_q;
                if (r_in_use != '0) begin
                    r_in_use <= r_in_use - CNT_W'(1);
                end
            end
            // output register
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // transaction datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_offset    <= i_in.addr - r_pool_base;
                r_status    <= ST_OK;
                r_elem_addr <= '0;
                r_q         <= '0;
                r_step      <= STEP_W'(IDX_W - 1);
            end
            S_RANGE: begin
                r_rem <= r_offset[SPAN_W-1:0];
                if (r_offset >= w_span) begin
                    r_status <= ST_FOREIGN;
                end
            end
            // one quotient bit per cycle, most significant first
            S_DIV: begin
                if (r_rem >= w_trial) begin
                    r_rem      <= r_rem - w_trial;
                    r_q[r_step] <= 1'b1;
                end
                r_step <= r_step - STEP_W'(1);
            end
            S_FREE_RD: begin
                if (r_rem != '0) begin
                    r_status <= ST_FOREIGN;
                end
            end
            S_FREE_WB: begin
                if (!w_taken) begin
                    r_status <= ST_DOUBLE;
                end
            end
            S_ALLOC: begin
                if (w_waiting != '0) begin
                    r_idx <= r_head;
                end else if (r_fresh != '0) begin
                    r_idx <= w_fresh_dec[IDX_W-1:0];
                end else begin
                    r_status <= ST_EMPTY;
                end
            end
            S_MUL: r_prod <= SPAN_W'(r_idx) * SPAN_W'(r_elem_size);
            S_ADD: r_elem_addr <= r_pool_base + ADDR_W'(r_prod);
            S_DONE: begin
                if (w_out_load) begin
                    r_out.status     <= r_status;
                    r_out.elem_addr  <= r_elem_addr;
                    r_out.used_count <= r_in_use;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_fresh} + {1'b0, r_in_use}) <= (CNT_W + 1)'(SLOTS))
        else $error("fresh and used counts exceed the pool");

    a_addr_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> (o_out.elem_addr == '0))
        else $error("element address set on a failed transaction");

    a_rem_below_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_RD) |-> (r_rem < SPAN_W'(r_elem_size)))
        else $error("divider remainder not below element size");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside of the done state");

    a_one_port_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_we && w_mem_re))
        else $error("memory read and write in the same cycle");

endmodule
`default_nettype wire
